// ----- rtl/core/ttb_pkg.sv -----
// Shared constants and handshake status types for the tangent/bitangent block.
package ttb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int OUT_WIDTH       = 32;

    // Job layout: JOB_FIELDS edge deltas, each COORD_WIDTH+1 bits, packed low field first.
    localparam int JOB_FIELDS = 10;
    localparam int J_DP1      = 0;
    localparam int J_DP2      = 3;
    localparam int J_DU1      = 6;
    localparam int J_DV1      = 7;
    localparam int J_DU2      = 8;
    localparam int J_DV2      = 9;

    typedef struct packed {
        logic full;
        logic empty;
    } ttb_q_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ttb_div_status_t;

endpackage

// ----- rtl/core/ttb_queue.sv -----
// Two-entry job queue between the vertex front end and the solver back end.
module ttb_queue import ttb_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [W-1:0]  wdata,
    input  logic          pop,
    output logic [W-1:0]  rdata,
    output ttb_q_status_t stat
);

    logic [W-1:0] ent_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   cnt_reg;

    assign rdata      = ent_reg[rptr_reg];
    assign stat.full  = cnt_reg[1];
    assign stat.empty = (cnt_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/core/ttb_front.sv -----
// Vertex front end: holds the first two vertices and queues edge deltas on the third.
module ttb_front import ttb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OUT_WIDTH-1:0] pos_x,
    input  logic [OUT_WIDTH-1:0] pos_y,
    input  logic [OUT_WIDTH-1:0] pos_z,
    input  logic [OUT_WIDTH-1:0] tex_u,
    input  logic [OUT_WIDTH-1:0] tex_v,
    input  ttb_q_status_t        qstat,
    output logic                 push,
    output logic [JOB_FIELDS*(COORD_WIDTH+1)-1:0] job
);

    localparam int DW1 = COORD_WIDTH + 1;

    typedef enum logic [1:0] {PH_V0, PH_V1, PH_V2} phase_t;

    phase_t                        phase_reg;
    logic signed [COORD_WIDTH-1:0] p0_reg [3];
    logic signed [COORD_WIDTH-1:0] p1_reg [3];
    logic signed [COORD_WIDTH-1:0] uv0_reg [2];
    logic signed [COORD_WIDTH-1:0] uv1_reg [2];
    logic signed [COORD_WIDTH-1:0] cur_p [3];
    logic signed [COORD_WIDTH-1:0] cur_uv [2];
    logic signed [DW1-1:0]         d [JOB_FIELDS];
    logic                          accept;

    assign cur_p[0]  = pos_x[COORD_WIDTH-1:0];
    assign cur_p[1]  = pos_y[COORD_WIDTH-1:0];
    assign cur_p[2]  = pos_z[COORD_WIDTH-1:0];
    assign cur_uv[0] = tex_u[COORD_WIDTH-1:0];
    assign cur_uv[1] = tex_v[COORD_WIDTH-1:0];

    // Only the closing vertex needs queue room.
    assign in_stall = (phase_reg == PH_V2) && qstat.full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (phase_reg == PH_V2);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[J_DP1+i] = DW1'(p1_reg[i]) - DW1'(p0_reg[i]);
            d[J_DP2+i] = DW1'(cur_p[i]) - DW1'(p0_reg[i]);
        end
        d[J_DU1] = DW1'(uv1_reg[0]) - DW1'(uv0_reg[0]);
        d[J_DV1] = DW1'(uv1_reg[1]) - DW1'(uv0_reg[1]);
        d[J_DU2] = DW1'(cur_uv[0]) - DW1'(uv0_reg[0]);
        d[J_DV2] = DW1'(cur_uv[1]) - DW1'(uv0_reg[1]);
        for (int k = 0; k < JOB_FIELDS; k++)
        begin
            job[k*DW1 +: DW1] = d[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_V0;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_V0:   phase_reg <= PH_V1;
                PH_V1:   phase_reg <= PH_V2;
                default: phase_reg <= PH_V0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_V0))
        begin
            p0_reg  <= cur_p;
            uv0_reg <= cur_uv;
        end
        if (accept && (phase_reg == PH_V1))
        begin
            p1_reg  <= cur_p;
            uv1_reg <= cur_uv;
        end
    end

endmodule

// ----- rtl/core/ttb_div.sv -----
// Bit-serial restoring divider for the scaled numerator, with overflow detect.
module ttb_div import ttb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [2*(COORD_WIDTH+1)-1:0]   num,
    input  logic [2*(COORD_WIDTH+1)-1:0]   den,
    output ttb_div_status_t                stat,
    output logic [COORD_WIDTH-1:0]         q,
    output logic                           ovf
);

    localparam int MAGW = 2 * (COORD_WIDTH + 1);
    localparam int SW   = MAGW + FRAC_BITS;
    localparam int HW   = SW - COORD_WIDTH;
    localparam int CMPW = (HW > MAGW) ? HW : MAGW;
    localparam int CNTW = $clog2(COORD_WIDTH + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic [MAGW-1:0]        rem_reg;
    logic [MAGW-1:0]        den_reg;
    logic [COORD_WIDTH-1:0] lq_reg;
    logic                   ovf_reg;
    logic [SW-1:0]          scaled;
    logic [CMPW-1:0]        h_ext;
    logic [CMPW-1:0]        den_ext;
    logic [MAGW:0]          trial;
    logic [MAGW:0]          trial_sub;
    logic                   fits;

    assign scaled    = {num, {FRAC_BITS{1'b0}}};
    assign h_ext     = CMPW'(scaled[SW-1:COORD_WIDTH]);
    assign den_ext   = CMPW'(den);
    assign trial     = {rem_reg, lq_reg[COORD_WIDTH-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign q         = lq_reg;
    assign ovf       = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(COORD_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // High part at or above the divisor means the quotient cannot fit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= h_ext[MAGW-1:0];
            lq_reg  <= scaled[COORD_WIDTH-1:0];
            den_reg <= den;
            ovf_reg <= (h_ext >= den_ext);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[MAGW-1:0] : trial[MAGW-1:0];
            lq_reg  <= {lq_reg[COORD_WIDTH-2:0], fits};
        end
    end

endmodule

// ----- rtl/core/ttb_back.sv -----
// Solver back end: sequences products, determinant, divisions and result beats.
module ttb_back import ttb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ttb_q_status_t                         qstat,
    input  logic [JOB_FIELDS*(COORD_WIDTH+1)-1:0] job,
    output logic                                  pop,
    output logic                                  div_start,
    output logic [2*(COORD_WIDTH+1)-1:0]          div_num,
    output logic [2*(COORD_WIDTH+1)-1:0]          div_den,
    input  ttb_div_status_t                       dstat,
    input  logic [COORD_WIDTH-1:0]                div_q,
    input  logic                                  div_ovf,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [OUT_WIDTH-1:0]           tangent_x,
    output logic signed [OUT_WIDTH-1:0]           tangent_y,
    output logic signed [OUT_WIDTH-1:0]           tangent_z,
    output logic signed [OUT_WIDTH-1:0]           bitangent_x,
    output logic signed [OUT_WIDTH-1:0]           bitangent_y,
    output logic signed [OUT_WIDTH-1:0]           bitangent_z,
    output logic                                  degenerate,
    output logic                                  last_of_triangle
);

    localparam int DW1  = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW1;
    localparam int NW   = PW + 1;
    localparam int MAGW = PW;
    localparam logic [COORD_WIDTH-1:0] LIM_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] LIM_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [1:0] LAST_BEAT = 2'd2;
    localparam logic [1:0] LAST_AXIS = 2'd2;

    typedef enum logic [2:0] {ST_IDLE, ST_MUL0, ST_MUL1, ST_COMBINE, ST_DIVIDE, ST_EMIT}
        state_t;

    state_t                        state_reg;
    logic                          det_phase_reg;
    logic                          is_b_reg;
    logic [1:0]                    axis_reg;
    logic [1:0]                    beat_reg;
    logic                          degen_reg;
    logic signed [COORD_WIDTH-1:0] vec_reg [6];
    logic signed [DW1-1:0]         jd_reg [JOB_FIELDS];
    logic signed [PW-1:0]          prod_reg;
    logic signed [PW-1:0]          acc_reg;
    logic [MAGW-1:0]               det_mag_reg;
    logic                          det_neg_reg;
    logic                          num_neg_reg;

    logic signed [DW1-1:0]         head [JOB_FIELDS];
    logic signed [DW1-1:0]         sel_dp1;
    logic signed [DW1-1:0]         sel_dp2;
    logic signed [DW1-1:0]         mul_a;
    logic signed [DW1-1:0]         mul_b;
    logic signed [PW-1:0]          mult;
    logic signed [NW-1:0]          diff;
    logic signed [NW-1:0]          diff_abs;
    logic                          diff_neg;
    logic [MAGW-1:0]               diff_mag;
    logic                          sat_neg;
    logic [COORD_WIDTH-1:0]        lim;
    logic [COORD_WIDTH-1:0]        sat_mag;
    logic [COORD_WIDTH-1:0]        sat_val;
    logic [2:0]                    comp_idx;

    always_comb
    begin
        for (int k = 0; k < JOB_FIELDS; k++)
        begin
            head[k] = job[k*DW1 +: DW1];
        end
    end

    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                sel_dp1 = jd_reg[J_DP1];
                sel_dp2 = jd_reg[J_DP2];
            end
            2'd1:
            begin
                sel_dp1 = jd_reg[J_DP1+1];
                sel_dp2 = jd_reg[J_DP2+1];
            end
            2'd2:
            begin
                sel_dp1 = jd_reg[J_DP1+2];
                sel_dp2 = jd_reg[J_DP2+2];
            end
            default:
            begin
                sel_dp1 = '0;
                sel_dp2 = '0;
            end
        endcase
    end

    // Second product of each pair is subtracted from the first.
    always_comb
    begin
        priority if (det_phase_reg)
        begin
            mul_a = (state_reg == ST_MUL0) ? jd_reg[J_DU1] : jd_reg[J_DV1];
            mul_b = (state_reg == ST_MUL0) ? jd_reg[J_DV2] : jd_reg[J_DU2];
        end
        else if (!is_b_reg)
        begin
            mul_a = (state_reg == ST_MUL0) ? sel_dp1 : sel_dp2;
            mul_b = (state_reg == ST_MUL0) ? jd_reg[J_DV2] : jd_reg[J_DV1];
        end
        else
        begin
            mul_a = (state_reg == ST_MUL0) ? sel_dp2 : sel_dp1;
            mul_b = (state_reg == ST_MUL0) ? jd_reg[J_DU1] : jd_reg[J_DU2];
        end
    end

    assign mult     = $signed(PW'(mul_a)) * $signed(PW'(mul_b));
    assign diff     = NW'(acc_reg) - NW'(prod_reg);
    assign diff_neg = diff[NW-1];
    assign diff_abs = diff_neg ? -diff : diff;
    assign diff_mag = diff_abs[MAGW-1:0];

    assign sat_neg  = (num_neg_reg ^ det_neg_reg) && (div_ovf || (div_q != '0));
    assign lim      = sat_neg ? LIM_NEG : LIM_POS;
    assign sat_mag  = (div_ovf || (div_q > lim)) ? lim : div_q;
    assign sat_val  = sat_neg ? (COORD_WIDTH'(0) - sat_mag) : sat_mag;
    assign comp_idx = {1'b0, axis_reg} + (is_b_reg ? 3'd3 : 3'd0);

    assign pop       = (state_reg == ST_IDLE) && !qstat.empty;
    assign div_start = (state_reg == ST_COMBINE) && !det_phase_reg;
    assign div_num   = diff_mag;
    assign div_den   = det_mag_reg;

    assign out_valid        = (state_reg == ST_EMIT);
    assign last_of_triangle = (beat_reg == LAST_BEAT);
    assign degenerate       = degen_reg;
    assign tangent_x        = OUT_WIDTH'(vec_reg[0]);
    assign tangent_y        = OUT_WIDTH'(vec_reg[1]);
    assign tangent_z        = OUT_WIDTH'(vec_reg[2]);
    assign bitangent_x      = OUT_WIDTH'(vec_reg[3]);
    assign bitangent_y      = OUT_WIDTH'(vec_reg[4]);
    assign bitangent_z      = OUT_WIDTH'(vec_reg[5]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            det_phase_reg <= 1'b0;
            is_b_reg      <= 1'b0;
            axis_reg      <= 2'd0;
            beat_reg      <= 2'd0;
            degen_reg     <= 1'b0;
            for (int k = 0; k < 6; k++)
            begin
                vec_reg[k] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        det_phase_reg <= 1'b1;
                        state_reg     <= ST_MUL0;
                    end
                end
                ST_MUL0:
                begin
                    state_reg <= ST_MUL1;
                end
                ST_MUL1:
                begin
                    state_reg <= ST_COMBINE;
                end
                ST_COMBINE:
                begin
                    if (det_phase_reg)
                    begin
                        beat_reg <= 2'd0;
                        if (diff_mag == '0)
                        begin
                            degen_reg <= 1'b1;
                            for (int k = 0; k < 6; k++)
                            begin
                                vec_reg[k] <= '0;
                            end
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            degen_reg     <= 1'b0;
                            det_phase_reg <= 1'b0;
                            is_b_reg      <= 1'b0;
                            axis_reg      <= 2'd0;
                            state_reg     <= ST_MUL0;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (dstat.done)
                    begin
                        for (int k = 0; k < 6; k++)
                        begin
                            if (comp_idx == 3'(k))
                            begin
                                vec_reg[k] <= sat_val;
                            end
                        end
                        priority if (is_b_reg && (axis_reg == LAST_AXIS))
                        begin
                            beat_reg  <= 2'd0;
                            state_reg <= ST_EMIT;
                        end
                        else if (axis_reg == LAST_AXIS)
                        begin
                            axis_reg  <= 2'd0;
                            is_b_reg  <= 1'b1;
                            state_reg <= ST_MUL0;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_MUL0;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        if (beat_reg == LAST_BEAT)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            beat_reg <= beat_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            jd_reg <= head;
        end
        if (state_reg == ST_MUL0)
        begin
            prod_reg <= mult;
        end
        if (state_reg == ST_MUL1)
        begin
            acc_reg  <= prod_reg;
            prod_reg <= mult;
        end
        if (state_reg == ST_COMBINE)
        begin
            if (det_phase_reg)
            begin
                det_mag_reg <= diff_mag;
                det_neg_reg <= diff_neg;
            end
            else
            begin
                num_neg_reg <= diff_neg;
            end
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !dstat.busy)
        else $error("divider started while busy");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_MUL0) && det_phase_reg)
        else $error("job pop did not start determinant");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (tangent_x == '0) && (tangent_y == '0)
            && (tangent_z == '0) && (bitangent_x == '0) && (bitangent_y == '0)
            && (bitangent_z == '0))
        else $error("degenerate beat with nonzero vector");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.done |-> (state_reg == ST_DIVIDE))
        else $error("quotient finished outside divide state");

endmodule

// ----- rtl/core/triangle_tangent_bitangent_top.sv -----
// Per-triangle tangent/bitangent generator: front end, job queue, solver, divider.
// Vertices one and two are held; the third queues a job, stalling while the queue is full.
// Solver time per job is set by the shared bit-serial divider (COORD_WIDTH steps per
// component); 3 result beats follow.
// A zero determinant skips the divisions and goes straight to the result beats.
// Reset (rst_n, async low) clears vertex phase, queue, sequencer, outputs; held data is not.
module triangle_tangent_bitangent_top import ttb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [OUT_WIDTH-1:0]        pos_x,
    input  logic [OUT_WIDTH-1:0]        pos_y,
    input  logic [OUT_WIDTH-1:0]        pos_z,
    input  logic [OUT_WIDTH-1:0]        tex_u,
    input  logic [OUT_WIDTH-1:0]        tex_v,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [OUT_WIDTH-1:0] tangent_x,
    output logic signed [OUT_WIDTH-1:0] tangent_y,
    output logic signed [OUT_WIDTH-1:0] tangent_z,
    output logic signed [OUT_WIDTH-1:0] bitangent_x,
    output logic signed [OUT_WIDTH-1:0] bitangent_y,
    output logic signed [OUT_WIDTH-1:0] bitangent_z,
    output logic                        degenerate,
    output logic                        last_of_triangle
);

    localparam int JW   = JOB_FIELDS * (COORD_WIDTH + 1);
    localparam int MAGW = 2 * (COORD_WIDTH + 1);

    ttb_q_status_t          qstat;
    ttb_div_status_t        dstat;
    logic                   push;
    logic                   pop;
    logic [JW-1:0]          job_in;
    logic [JW-1:0]          job_out;
    logic                   div_start;
    logic [MAGW-1:0]        div_num;
    logic [MAGW-1:0]        div_den;
    logic [COORD_WIDTH-1:0] div_q;
    logic                   div_ovf;

    ttb_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .tex_u    (tex_u),
        .tex_v    (tex_v),
        .qstat    (qstat),
        .push     (push),
        .job      (job_in)
    );

    ttb_queue #(.W(JW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .pop   (pop),
        .rdata (job_out),
        .stat  (qstat)
    );

    ttb_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (dstat),
        .q     (div_q),
        .ovf   (div_ovf)
    );

    ttb_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .qstat            (qstat),
        .job              (job_out),
        .pop              (pop),
        .div_start        (div_start),
        .div_num          (div_num),
        .div_den          (div_den),
        .dstat            (dstat),
        .div_q            (div_q),
        .div_ovf          (div_ovf),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .tangent_x        (tangent_x),
        .tangent_y        (tangent_y),
        .tangent_z        (tangent_z),
        .bitangent_x      (bitangent_x),
        .bitangent_y      (bitangent_y),
        .bitangent_z      (bitangent_z),
        .degenerate       (degenerate),
        .last_of_triangle (last_of_triangle)
    );

endmodule

// ----- sim/testbench.sv -----
// Testbench for the triangle tangent/bitangent block: random and directed vertex stream.
`timescale 1ns / 1ps

module testbench;
    import ttb_pkg::*;

    typedef struct {
        logic [31:0] px, py, pz, u, v;
        bit          pause;
    } vertex_t;

    typedef struct packed {
        logic [31:0] tx, ty, tz, bx, by, bz;
        logic        degen, last;
    } frame_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
    logic signed [31:0] tangent_x, tangent_y, tangent_z;
    logic signed [31:0] bitangent_x, bitangent_y, bitangent_z;
    logic degenerate, last_of_triangle;

    triangle_tangent_bitangent_top dut (.*);

    vertex_t pending_verts[$];
    frame_t  frames_due[$];

    // predictor state: vertex phase and the two held vertices
    int          corner_count;
    logic [31:0] held_vert[2][5];

    int verts_sent, beats_seen, tris_done, degen_tris, errors, quiet_cycles;
    bit long_hold_done;
    int hold_left;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [127:0] wide(logic [31:0] x);
        return 128'(signed'(x));
    endfunction

    function automatic logic [31:0] sat_quot(logic signed [127:0] n, logic signed [127:0] d);
        logic signed [127:0] q;
        q = (n <<< FRAC_BITS_DEF) / d;
        if (q > 128'sd2147483647)
            return 32'h7fffffff;
        if (q < -128'sd2147483648)
            return 32'h80000000;
        return q[31:0];
    endfunction

    task automatic solve_vertex(vertex_t vx);
        logic [31:0] cur[5];
        logic signed [127:0] dp1[3], dp2[3], du1, dv1, du2, dv2, det;
        frame_t f;
        cur = '{vx.px, vx.py, vx.pz, vx.u, vx.v};
        if (corner_count < 2)
        begin
            held_vert[corner_count] = cur;
            corner_count++;
            return;
        end
        corner_count = 0;
        for (int i = 0; i < 3; i++)
        begin
            dp1[i] = wide(held_vert[1][i]) - wide(held_vert[0][i]);
            dp2[i] = wide(cur[i]) - wide(held_vert[0][i]);
        end
        du1 = wide(held_vert[1][3]) - wide(held_vert[0][3]);
        dv1 = wide(held_vert[1][4]) - wide(held_vert[0][4]);
        du2 = wide(cur[3]) - wide(held_vert[0][3]);
        dv2 = wide(cur[4]) - wide(held_vert[0][4]);
        det = du1 * dv2 - dv1 * du2;
        f = '0;
        f.degen = (det == 0);
        if (!f.degen)
        begin
            f.tx = sat_quot(dp1[0] * dv2 - dp2[0] * dv1, det);
            f.ty = sat_quot(dp1[1] * dv2 - dp2[1] * dv1, det);
            f.tz = sat_quot(dp1[2] * dv2 - dp2[2] * dv1, det);
            f.bx = sat_quot(dp2[0] * du1 - dp1[0] * du2, det);
            f.by = sat_quot(dp2[1] * du1 - dp1[1] * du2, det);
            f.bz = sat_quot(dp2[2] * du1 - dp1[2] * du2, det);
        end
        else
            degen_tris++;
        tris_done++;
        for (int k = 0; k < 3; k++)
        begin
            f.last = (k == 2);
            frames_due.insert(frames_due.size(), f);
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    function automatic int send_idle_pct();
        if (verts_sent < 120)
            return 12;
        if (verts_sent < 240)
            return 72;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (verts_sent < 120)
            return 72;
        if (verts_sent < 240)
            return 12;
        return 0;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        vertex_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                solve_vertex('{pos_x, pos_y, pos_z, tex_u, tex_v, 1'b0});
                verts_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                // drop a pause marker once every result is back
                if (pending_verts.size() > 0 && pending_verts[0].pause && frames_due.size() == 0)
                    void'(pending_verts.pop_front());
                if (pending_verts.size() > 0 && !pending_verts[0].pause
                    && $urandom_range(99) >= send_idle_pct())
                begin
                    nxt = pending_verts.pop_front();
                    pos_x <= nxt.px;
                    pos_y <= nxt.py;
                    pos_z <= nxt.pz;
                    tex_u <= nxt.u;
                    tex_v <= nxt.v;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin : mon_blk
        frame_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_seen++;
                if (frames_due.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    e = frames_due.pop_front();
                    check_field("tangent_x", e.tx, tangent_x);
                    check_field("tangent_y", e.ty, tangent_y);
                    check_field("tangent_z", e.tz, tangent_z);
                    check_field("bitangent_x", e.bx, bitangent_x);
                    check_field("bitangent_y", e.by, bitangent_y);
                    check_field("bitangent_z", e.bz, bitangent_z);
                    check_field("degenerate", e.degen, degenerate);
                    check_field("last_of_triangle", e.last, last_of_triangle);
                end
            end
            // hold off for a long stretch once so the job queue backs up
            if (!long_hold_done && verts_sent >= 270)
            begin
                long_hold_done = 1;
                hold_left = 900;
            end
            if (hold_left > 0)
                hold_left--;
            out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct());
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(65535 * 8)) - 65535 * 4);
            2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                        : 32'h80000000 + $urandom_range(3);
            default: return 32'($signed($urandom_range(1023)) - 512) <<< 10;
        endcase
    endfunction

    task automatic add_vert(logic [31:0] px, py, pz, u, v);
        pending_verts.insert(pending_verts.size(), '{px, py, pz, u, v, 1'b0});
    endtask

    task automatic add_pause();
        pending_verts.insert(pending_verts.size(), '{0, 0, 0, 0, 0, 1'b1});
    endtask

    initial
    begin
        logic [31:0] a, b;
        quiet_cycles = 0;
        corner_count = 0;
        in_valid = 0;
        out_stall = 0;
        pos_x = 0; pos_y = 0; pos_z = 0; tex_u = 0; tex_v = 0;
        rst_n = 0;
        // all zero: degenerate
        repeat (3) add_vert(0, 0, 0, 0, 0);
        // unit right triangle in UV
        add_vert(0, 0, 0, 0, 0);
        add_vert(32'h10000, 0, 0, 32'h10000, 0);
        add_vert(0, 32'h10000, 0, 0, 32'h10000);
        // collinear UVs: degenerate with nonzero positions
        add_vert(32'h1234, 32'h5678, 32'h9abc, 32'h10000, 32'h10000);
        add_vert(32'h7fffffff, 32'h80000000, 32'h1, 32'h20000, 32'h20000);
        add_vert(32'hffffffff, 32'h0, 32'h80000000, 32'h30000, 32'h30000);
        // extreme positions with a tiny determinant: saturation both ways
        add_vert(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0);
        add_vert(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 0);
        add_vert(32'h80000000, 32'h80000000, 32'h7fffffff, 0, 1);
        // extreme UVs
        add_vert(32'h00010000, 32'hffff0000, 32'h0, 32'h80000000, 32'h80000000);
        add_vert(32'h00020000, 32'h0, 32'h00030000, 32'h7fffffff, 32'h80000000);
        add_vert(32'hfffe0000, 32'h00050000, 32'h0, 32'h80000000, 32'h7fffffff);
        // negative determinant, small values
        add_vert(32'hfff00000, 32'h00100000, 32'h0, 32'h00008000, 32'h0);
        add_vert(32'h0, 32'h0, 32'h00100000, 32'h0, 32'h00008000);
        add_vert(32'h00100000, 32'hfff00000, 32'h0, 32'h00008000, 32'h00008000);
        // all ones everywhere, but the last corner's U is 0x7fffffff
        repeat (2) add_vert('1, '1, '1, '1, '1);
        add_vert('1, '1, '1, 32'h7fffffff, '1);
        add_pause();
        for (int t = 0; t < 120; t++)
        begin
            if ($urandom_range(9) == 0)
            begin
                // degenerate: repeat one UV on two corners
                a = rnd_coord();
                b = rnd_coord();
                add_vert(rnd_coord(), rnd_coord(), rnd_coord(), a, b);
                add_vert(rnd_coord(), rnd_coord(), rnd_coord(), a, b);
                add_vert(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            end
            else
                repeat (3) add_vert(rnd_coord(), rnd_coord(), rnd_coord(),
                                    rnd_coord(), rnd_coord());
            if (t == 50)
                add_pause();
        end
        repeat (2) @(posedge clk);
        rst_n <= 1;
        while (pending_verts.size() > 0 || in_valid || frames_due.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Covered %0d triangles (%0d degenerate), %0d vertex beats, %0d result beats.",
                 tris_done, degen_tris, verts_sent, beats_seen);
        if (errors == 0 && frames_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
